/* rtl/core/cpfa_pkg.sv */
// Shared constants, codes and types of the contiguous page frame allocator.
`timescale 1ns / 1ps
`default_nettype none

package cpfa_pkg;

    // Geometry
    localparam int FRAMES     = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int FIDX_W     = $clog2(FRAMES);
    localparam int FCNT_W     = FIDX_W + 1;

    // Bitmap rows: one memory row holds the used bits of ROW_BITS frames
    localparam int ROW_BITS  = 8;
    localparam int ROW_SHIFT = $clog2(ROW_BITS);
    localparam int ROWS      = FRAMES / ROW_BITS;
    localparam int ROW_W     = $clog2(ROWS);

    // Request and result field widths
    localparam int SIZE_W   = 32;
    localparam int ADDR_W   = 32;
    localparam int NEED_W   = SIZE_W - PAGE_SHIFT + 1;
    localparam int ST_W     = 3;
    localparam int BASE_W   = 23;
    localparam int FF_W     = 11;
    localparam int PL_W     = 2;
    localparam int IN_DW    = SIZE_W + ADDR_W;
    localparam int OUT_FW   = ST_W + BASE_W + FF_W + PL_W;
    localparam int OUT_DW   = ((OUT_FW + 7) / 8) * 8;

    // Pressure thresholds on free*100
    localparam int PCT_W     = FCNT_W + 7;
    localparam int PCT_SCALE = 100;
    localparam int PCT_CRIT  = 5 * FRAMES;
    localparam int PCT_LOW   = 10 * FRAMES;
    localparam int PCT_MOD   = 15 * FRAMES;

    // Commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_ZERO    = 3'd1;
    localparam logic [ST_W-1:0] ST_OOM     = 3'd2;
    localparam logic [ST_W-1:0] ST_NORUN   = 3'd3;
    localparam logic [ST_W-1:0] ST_IGNORED = 3'd4;

    // Pressure levels
    localparam logic [PL_W-1:0] PL_NORMAL   = 2'd0;
    localparam logic [PL_W-1:0] PL_MODERATE = 2'd1;
    localparam logic [PL_W-1:0] PL_LOW      = 2'd2;
    localparam logic [PL_W-1:0] PL_CRITICAL = 2'd3;

    typedef struct packed {
        logic              zero;
        logic [NEED_W-1:0] need;
        logic              low;
        logic              oom;
        logic [PL_W-1:0]   pressure;
    } t_size_info;

    typedef struct packed {
        logic              found;
        logic [FCNT_W-1:0] found_start;
        logic [FCNT_W-1:0] run_start;
        logic [FCNT_W-1:0] count;
    } t_scan_res;

endpackage

`default_nettype wire

/* rtl/core/cpfa_bitmap_ram.sv */
// Frame used-bit memory: synchronous RAM rows with per-row valid flags cleared at reset.
`timescale 1ns / 1ps
`default_nettype none

module cpfa_bitmap_ram (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [cpfa_pkg::ROW_W-1:0]     i_rd_addr,
    output logic      [cpfa_pkg::ROW_BITS-1:0]  o_rd_data,
    input  wire logic                           i_wr_en,
    input  wire logic [cpfa_pkg::ROW_W-1:0]     i_wr_addr,
    input  wire logic [cpfa_pkg::ROW_BITS-1:0]  i_wr_data
);

    logic [cpfa_pkg::ROW_BITS-1:0] r_mem [cpfa_pkg::ROWS];
    logic [cpfa_pkg::ROWS-1:0]     r_row_vld;
    logic [cpfa_pkg::ROW_BITS-1:0] r_rd_data;
    logic                          r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // A row never written reads as all frames free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_row_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

/* rtl/core/cpfa_sizer.sv */
// Allocation sizing: page count, low-memory and out-of-memory checks, pressure level.
`timescale 1ns / 1ps
`default_nettype none

module cpfa_sizer (
    input  wire logic [cpfa_pkg::SIZE_W-1:0] i_size,
    input  wire logic [cpfa_pkg::FCNT_W-1:0] i_free_cnt,
    output cpfa_pkg::t_size_info             o_info
);

    logic [cpfa_pkg::NEED_W-1:0] need;
    logic [cpfa_pkg::NEED_W-1:0] free_ext;
    logic [cpfa_pkg::PCT_W-1:0]  pct;

    // Pages of the 8-byte rounded size equal pages of the raw size.
    assign need = cpfa_pkg::NEED_W'(i_size >> cpfa_pkg::PAGE_SHIFT)
                + cpfa_pkg::NEED_W'(|i_size[cpfa_pkg::PAGE_SHIFT-1:0]);
    assign free_ext = cpfa_pkg::NEED_W'(i_free_cnt);
    assign pct = cpfa_pkg::PCT_W'(i_free_cnt) * cpfa_pkg::PCT_W'(cpfa_pkg::PCT_SCALE);

    always_comb begin
        o_info.zero = (i_size == '0);
        o_info.need = need;
        // free*page < rounded + page  <=>  free <= pages
        o_info.low  = (free_ext <= need);
        o_info.oom  = (free_ext < need);
        priority if (pct < cpfa_pkg::PCT_W'(cpfa_pkg::PCT_CRIT)) begin
            o_info.pressure = cpfa_pkg::PL_CRITICAL;
        end else if (pct < cpfa_pkg::PCT_W'(cpfa_pkg::PCT_LOW)) begin
            o_info.pressure = cpfa_pkg::PL_LOW;
        end else if (pct < cpfa_pkg::PCT_W'(cpfa_pkg::PCT_MOD)) begin
            o_info.pressure = cpfa_pkg::PL_MODERATE;
        end else begin
            o_info.pressure = cpfa_pkg::PL_NORMAL;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cpfa_row_scan.sv */
// One bitmap row of the next-fit search: extends or restarts the free run frame by frame.
`timescale 1ns / 1ps
`default_nettype none

module cpfa_row_scan (
    input  wire logic [cpfa_pkg::ROW_BITS-1:0]  i_row_data,
    input  wire logic [cpfa_pkg::ROW_W-1:0]     i_row,
    input  wire logic [cpfa_pkg::ROW_SHIFT-1:0] i_offset,
    input  wire logic [cpfa_pkg::NEED_W-1:0]    i_need,
    input  wire logic [cpfa_pkg::FCNT_W-1:0]    i_run_start,
    input  wire logic [cpfa_pkg::FCNT_W-1:0]    i_count,
    output cpfa_pkg::t_scan_res                 o_res
);

    logic [cpfa_pkg::FCNT_W-1:0] start;
    logic [cpfa_pkg::FCNT_W-1:0] cnt;
    logic [cpfa_pkg::FCNT_W-1:0] fstart;
    logic                        found;

    always_comb begin
        start  = i_run_start;
        cnt    = i_count;
        fstart = i_run_start;
        found  = 1'b0;
        for (int b = 0; b < cpfa_pkg::ROW_BITS; b++) begin
            if (cpfa_pkg::ROW_SHIFT'(b) >= i_offset && !found) begin
                if (i_row_data[b]) begin
                    // used frame: run restarts just past it
                    start = cpfa_pkg::FCNT_W'({i_row, cpfa_pkg::ROW_SHIFT'(b)})
                          + cpfa_pkg::FCNT_W'(1);
                    cnt   = '0;
                end else begin
                    cnt = cnt + cpfa_pkg::FCNT_W'(1);
                    if (cpfa_pkg::NEED_W'(cnt) == i_need) begin
                        found  = 1'b1;
                        fstart = start;
                    end
                end
            end
        end
        o_res.found       = found;
        o_res.found_start = fstart;
        o_res.run_start   = start;
        o_res.count       = cnt;
    end

endmodule

`default_nettype wire

/* rtl/core/contiguous_page_frame_allocator_core.sv */
// Top level: request sequencer of the next-fit contiguous page frame allocator.
// Free: decide, then check and clear the frame; an address out of range goes straight to the result.
// Allocate: rows scanned from the hint (8 frames a cycle), then the rows of the run read and marked;
// a failed search ends after the scan; zero size, out of memory or hint at the end skip the scan.
// One request is in flight at a time; the next is taken while a result waits at the output.
// Reset is synchronous: hint 0, all frames free, pressure normal; rows read free until written.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_page_frame_allocator_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] size_bytes, [63:32] free_address
    input  wire logic [cpfa_pkg::IN_DW-1:0]    s_axis_tdata,
    // [0] command
    input  wire logic [0:0]                    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [2:0] status, [25:3] base_address, [36:26] free_frames, [38:37] pressure_level
    output logic      [cpfa_pkg::OUT_DW-1:0]   m_axis_tdata
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECIDE   = 3'd1;
    localparam logic [2:0] S_FREE_CHK = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_MARK_RD  = 3'd4;
    localparam logic [2:0] S_MARK_WR  = 3'd5;
    localparam logic [2:0] S_FIN      = 3'd6;

    localparam int HI_W = cpfa_pkg::ADDR_W - cpfa_pkg::PAGE_SHIFT - cpfa_pkg::FIDX_W;

    logic [2:0]                       r_state, n_state;
    logic                             r_cmd;
    logic [cpfa_pkg::SIZE_W-1:0]      r_size;
    logic [cpfa_pkg::ADDR_W-1:0]      r_addr;
    logic [cpfa_pkg::FCNT_W-1:0]      r_hint;
    logic [cpfa_pkg::FCNT_W-1:0]      r_free_cnt;
    logic [cpfa_pkg::PL_W-1:0]        r_pressure;
    logic [cpfa_pkg::ST_W-1:0]        r_status;
    logic [cpfa_pkg::BASE_W-1:0]      r_base;
    logic [cpfa_pkg::ROW_W-1:0]       r_row;
    logic [cpfa_pkg::ROW_SHIFT-1:0]   r_off;
    logic [cpfa_pkg::FCNT_W-1:0]      r_run_start;
    logic [cpfa_pkg::FCNT_W-1:0]      r_count;
    logic [cpfa_pkg::NEED_W-1:0]      r_need;
    logic [cpfa_pkg::FIDX_W-1:0]      r_end;
    logic                             r_out_valid;
    logic [cpfa_pkg::OUT_DW-1:0]      r_out_data;

    cpfa_pkg::t_size_info             size_info;
    cpfa_pkg::t_scan_res              scan_res;

    logic [cpfa_pkg::ROW_W-1:0]       rd_addr;
    logic [cpfa_pkg::ROW_BITS-1:0]    rd_data;
    logic                             wr_en;
    logic [cpfa_pkg::ROW_W-1:0]       wr_addr;
    logic [cpfa_pkg::ROW_BITS-1:0]    wr_data;
    logic [cpfa_pkg::ROW_BITS-1:0]    mark_mask;
    logic [cpfa_pkg::FCNT_W-1:0]      mark_frame;

    logic [cpfa_pkg::FIDX_W-1:0]      free_frame;
    logic                             free_bad;
    logic [cpfa_pkg::FIDX_W-1:0]      chk_frame;
    logic                             chk_used;
    logic [cpfa_pkg::FCNT_W-1:0]      hint_row_frame;
    logic                             scan_last_row;
    logic                             mark_last_row;
    logic                             out_load;

    cpfa_bitmap_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    cpfa_sizer u_sizer (
        .i_size     (r_size),
        .i_free_cnt (r_free_cnt),
        .o_info     (size_info)
    );

    cpfa_row_scan u_scan (
        .i_row_data  (rd_data),
        .i_row       (r_row),
        .i_offset    (r_off),
        .i_need      (r_need),
        .i_run_start (r_run_start),
        .i_count     (r_count),
        .o_res       (scan_res)
    );

    assign free_frame = r_addr[cpfa_pkg::PAGE_SHIFT +: cpfa_pkg::FIDX_W];
    assign free_bad   = (r_addr == '0)
                      || (r_addr[cpfa_pkg::ADDR_W-1 -: HI_W] != '0);
    assign chk_frame  = {r_row, r_off};
    assign chk_used   = rd_data[r_off];
    assign hint_row_frame = r_hint;

    assign scan_last_row = (r_row == cpfa_pkg::ROW_W'(cpfa_pkg::ROWS - 1));
    assign mark_last_row = (r_row == r_end[cpfa_pkg::FIDX_W-1:cpfa_pkg::ROW_SHIFT]);
    assign out_load      = (r_state == S_FIN) && (!r_out_valid || m_axis_tready);

    // Frames of the current row that fall inside the run being marked
    always_comb begin
        mark_frame = '0;
        mark_mask  = '0;
        for (int j = 0; j < cpfa_pkg::ROW_BITS; j++) begin
            mark_frame   = cpfa_pkg::FCNT_W'({r_row, cpfa_pkg::ROW_SHIFT'(j)});
            mark_mask[j] = (mark_frame >= r_run_start)
                         && (mark_frame <= cpfa_pkg::FCNT_W'(r_end));
        end
    end

    // Memory port control. Items run one at a time and the last write of an
    // item lands before the next item's first read, so no forwarding is needed.
    always_comb begin
        rd_addr = r_row;
        wr_en   = 1'b0;
        wr_addr = r_row;
        wr_data = rd_data | mark_mask;
        unique case (r_state)
            S_DECIDE: begin
                if (r_cmd == cpfa_pkg::CMD_FREE) begin
                    rd_addr = free_frame[cpfa_pkg::FIDX_W-1:cpfa_pkg::ROW_SHIFT];
                end else begin
                    rd_addr = hint_row_frame[cpfa_pkg::FIDX_W-1:cpfa_pkg::ROW_SHIFT];
                end
            end
            S_FREE_CHK: begin
                wr_en   = chk_used;
                wr_data = rd_data & ~(cpfa_pkg::ROW_BITS'(1) << r_off);
            end
            S_SCAN: begin
                rd_addr = r_row + cpfa_pkg::ROW_W'(1);
            end
            S_MARK_RD: begin
                rd_addr = r_run_start[cpfa_pkg::FIDX_W-1:cpfa_pkg::ROW_SHIFT];
            end
            S_MARK_WR: begin
                wr_en   = 1'b1;
                rd_addr = r_row + cpfa_pkg::ROW_W'(1);
            end
            S_IDLE, S_FIN: begin
                rd_addr = r_row;
            end
            default: begin
                rd_addr = r_row;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_cmd == cpfa_pkg::CMD_FREE) begin
                    n_state = free_bad ? S_FIN : S_FREE_CHK;
                end else if (size_info.zero || (size_info.low && size_info.oom)
                             || r_hint >= cpfa_pkg::FCNT_W'(cpfa_pkg::FRAMES)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_FREE_CHK: n_state = S_FIN;
            S_SCAN: begin
                if (scan_res.found) begin
                    n_state = S_MARK_RD;
                end else if (scan_last_row) begin
                    n_state = S_FIN;
                end
            end
            S_MARK_RD: n_state = S_MARK_WR;
            S_MARK_WR: begin
                if (mark_last_row) n_state = S_FIN;
            end
            S_FIN: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hint      <= '0;
            r_free_cnt  <= cpfa_pkg::FCNT_W'(cpfa_pkg::FRAMES);
            r_pressure  <= cpfa_pkg::PL_NORMAL;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_DECIDE: begin
                    if (r_cmd == cpfa_pkg::CMD_ALLOC && !size_info.zero && size_info.low) begin
                        r_pressure <= size_info.pressure;
                    end
                end
                S_FREE_CHK: begin
                    if (chk_used) begin
                        r_free_cnt <= r_free_cnt + cpfa_pkg::FCNT_W'(1);
                        if (cpfa_pkg::FCNT_W'(chk_frame) < r_hint) begin
                            r_hint <= cpfa_pkg::FCNT_W'(chk_frame);
                        end
                    end
                end
                S_SCAN: begin
                    // a failed search keeps the advance past used frames
                    if (!scan_res.found && scan_last_row) begin
                        r_hint <= scan_res.run_start;
                    end
                end
                S_MARK_WR: begin
                    if (mark_last_row) begin
                        r_free_cnt <= r_free_cnt - r_need[cpfa_pkg::FCNT_W-1:0];
                        r_hint     <= cpfa_pkg::FCNT_W'(r_end) + cpfa_pkg::FCNT_W'(1);
                    end
                end
                S_IDLE, S_MARK_RD, S_FIN: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Request and working payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= cpfa_pkg::OUT_DW'({r_pressure,
                                             cpfa_pkg::FF_W'(r_free_cnt),
                                             r_base,
                                             r_status});
        end
        unique case (r_state)
            S_IDLE: begin
                r_cmd  <= s_axis_tuser[0];
                r_size <= s_axis_tdata[cpfa_pkg::SIZE_W-1:0];
                r_addr <= s_axis_tdata[cpfa_pkg::IN_DW-1:cpfa_pkg::SIZE_W];
            end
            S_DECIDE: begin
                r_base  <= '0;
                r_need  <= size_info.need;
                r_count <= '0;
                r_run_start <= r_hint;
                if (r_cmd == cpfa_pkg::CMD_FREE) begin
                    r_status <= cpfa_pkg::ST_IGNORED;
                    r_row    <= free_frame[cpfa_pkg::FIDX_W-1:cpfa_pkg::ROW_SHIFT];
                    r_off    <= free_frame[cpfa_pkg::ROW_SHIFT-1:0];
                end else begin
                    priority if (size_info.zero) begin
                        r_status <= cpfa_pkg::ST_ZERO;
                    end else if (size_info.low && size_info.oom) begin
                        r_status <= cpfa_pkg::ST_OOM;
                    end else begin
                        r_status <= cpfa_pkg::ST_NORUN;
                    end
                    r_row <= hint_row_frame[cpfa_pkg::FIDX_W-1:cpfa_pkg::ROW_SHIFT];
                    r_off <= hint_row_frame[cpfa_pkg::ROW_SHIFT-1:0];
                end
            end
            S_FREE_CHK: begin
                r_status <= chk_used ? cpfa_pkg::ST_OK : cpfa_pkg::ST_IGNORED;
            end
            S_SCAN: begin
                if (scan_res.found) begin
                    r_run_start <= scan_res.found_start;
                    r_end       <= cpfa_pkg::FIDX_W'(scan_res.found_start
                                 + r_need[cpfa_pkg::FCNT_W-1:0] - cpfa_pkg::FCNT_W'(1));
                end else begin
                    r_row       <= r_row + cpfa_pkg::ROW_W'(1);
                    r_off       <= '0;
                    r_run_start <= scan_res.run_start;
                    r_count     <= scan_res.count;
                end
            end
            S_MARK_RD: begin
                r_row <= r_run_start[cpfa_pkg::FIDX_W-1:cpfa_pkg::ROW_SHIFT];
            end
            S_MARK_WR: begin
                r_row <= r_row + cpfa_pkg::ROW_W'(1);
                if (mark_last_row) begin
                    r_status <= cpfa_pkg::ST_OK;
                    r_base   <= cpfa_pkg::BASE_W'(r_run_start[cpfa_pkg::FIDX_W-1:0])
                                << cpfa_pkg::PAGE_SHIFT;
                end
            end
            S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

/* rtl/core/cpfa_checker.sv */
// Port-level assertions for the allocator core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cpfa_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        s_axis_tvalid,
    input wire logic                        s_axis_tready,
    input wire logic [cpfa_pkg::IN_DW-1:0]  s_axis_tdata,
    input wire logic [0:0]                  s_axis_tuser,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [cpfa_pkg::OUT_DW-1:0] m_axis_tdata
);

    logic [cpfa_pkg::ST_W-1:0]   o_status;
    logic [cpfa_pkg::BASE_W-1:0] o_base;
    logic [cpfa_pkg::FF_W-1:0]   o_free;
    logic                        in_xfer;

    assign o_status = m_axis_tdata[cpfa_pkg::ST_W-1:0];
    assign o_base   = m_axis_tdata[cpfa_pkg::ST_W +: cpfa_pkg::BASE_W];
    assign o_free   = m_axis_tdata[cpfa_pkg::ST_W + cpfa_pkg::BASE_W +: cpfa_pkg::FF_W];
    assign in_xfer  = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '1 || s_axis_tuser != '1
                      || s_axis_tdata == '1);

    // one request in flight: no transfer in the cycle right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input taken while a request is in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (o_status == cpfa_pkg::ST_OK || o_status == cpfa_pkg::ST_ZERO
                           || o_status == cpfa_pkg::ST_OOM || o_status == cpfa_pkg::ST_NORUN
                           || o_status == cpfa_pkg::ST_IGNORED))
        else $error("undefined status code");

    a_base_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && o_status != cpfa_pkg::ST_OK) |-> (o_base == '0))
        else $error("base address on a failed request");

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (o_free <= cpfa_pkg::FF_W'(cpfa_pkg::FRAMES)))
        else $error("free frame count beyond frame total");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind contiguous_page_frame_allocator_core cpfa_checker u_cpfa_checker (.*);

`default_nettype wire
